[rtl/core/pi_velocity_controller_antiwindup_assert.svh]
// Assertion macros for the PI velocity controller checker.
`ifndef PI_VELOCITY_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PI_VELOCITY_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define PIVCA_ASSERT_RST(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pivca assertion failed");

// Clocked assertion that also holds during reset.
`define PIVCA_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("pivca assertion failed");

`endif

[rtl/core/pivca_pkg.sv]
// Shared types, constants and a saturation helper for the PI velocity controller.
`timescale 1ns / 1ps
`default_nettype none

package pivca_pkg;

    localparam int DATA_W        = 32;
    localparam int GAIN_W        = 31;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_W        = 5;
    localparam int IDX_W         = 3;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = 31'd65536;
    localparam logic [GAIN_W-1:0] GAIN_ZERO = 31'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_POS_GAIN   = 3'd0,
        REG_YAW_GAIN   = 3'd1,
        REG_POS_IGAIN  = 3'd2,
        REG_YAW_IGAIN  = 3'd3,
        REG_VEL_LIMIT  = 3'd4,
        REG_YAW_LIMIT  = 3'd5,
        REG_POS_WINDUP = 3'd6,
        REG_YAW_WINDUP = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] pos_kp;
        logic [GAIN_W-1:0] yaw_kp;
        logic [GAIN_W-1:0] position_integral_step_gain;
        logic [GAIN_W-1:0] yaw_integral_step_gain;
        logic [GAIN_W-1:0] velocity_limit;
        logic [GAIN_W-1:0] turn_rate_limit;
        logic [GAIN_W-1:0] position_windup_value;
        logic [GAIN_W-1:0] yaw_windup_value;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] sensed_x;
        logic signed [DATA_W-1:0] sensed_y;
        logic signed [DATA_W-1:0] sensed_z;
        logic signed [DATA_W-1:0] sensed_yaw;
        logic signed [DATA_W-1:0] target_x;
        logic signed [DATA_W-1:0] target_y;
        logic signed [DATA_W-1:0] target_z;
        logic signed [DATA_W-1:0] target_yaw;
        logic                     clear_integrators;
    } t_sample;

    typedef struct packed {
        logic signed [DATA_W-1:0] prop_x;
        logic signed [DATA_W-1:0] prop_y;
        logic signed [DATA_W-1:0] prop_z;
        logic signed [DATA_W-1:0] prop_yaw;
        logic signed [DATA_W-1:0] integ_x;
        logic signed [DATA_W-1:0] integ_y;
        logic signed [DATA_W-1:0] integ_yaw;
        logic                     clear_integrators;
    } t_terms;

    // Saturate a one-bit-grown sum to the data range.
    function automatic logic signed [DATA_W-1:0] sat_grow1(
        input logic signed [DATA_W:0] v
    );
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1]) begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/pivca_regs.sv]
// APB register file holding the controller gains, limits and windup values.
`timescale 1ns / 1ps
`default_nettype none

module pivca_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pivca_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pivca_pkg::DATA_W-1:0]  pwdata,
    output logic      [pivca_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    output pivca_pkg::t_cfg                    o_cfg
);
    import pivca_pkg::*;

    t_cfg              r_cfg;
    t_reg_idx          idx;
    logic              wr_en;
    logic [GAIN_W-1:0] wr_val;
    logic [GAIN_W-1:0] rd_val;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign wr_val = pwdata[GAIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_kp                      <= GAIN_ONE;
            r_cfg.yaw_kp                      <= GAIN_ONE;
            r_cfg.position_integral_step_gain <= GAIN_ZERO;
            r_cfg.yaw_integral_step_gain      <= GAIN_ZERO;
            r_cfg.velocity_limit              <= GAIN_ONE;
            r_cfg.turn_rate_limit             <= GAIN_ONE;
            r_cfg.position_windup_value       <= GAIN_ZERO;
            r_cfg.yaw_windup_value            <= GAIN_ZERO;
        end else if (wr_en) begin
            unique case (idx)
                REG_POS_GAIN:   r_cfg.pos_kp                      <= wr_val;
                REG_YAW_GAIN:   r_cfg.yaw_kp                      <= wr_val;
                REG_POS_IGAIN:  r_cfg.position_integral_step_gain <= wr_val;
                REG_YAW_IGAIN:  r_cfg.yaw_integral_step_gain      <= wr_val;
                REG_VEL_LIMIT:  r_cfg.velocity_limit              <= wr_val;
                REG_YAW_LIMIT:  r_cfg.turn_rate_limit             <= wr_val;
                REG_POS_WINDUP: r_cfg.position_windup_value       <= wr_val;
                REG_YAW_WINDUP: r_cfg.yaw_windup_value            <= wr_val;
                default:        r_cfg                             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_POS_GAIN:   rd_val = r_cfg.pos_kp;
            REG_YAW_GAIN:   rd_val = r_cfg.yaw_kp;
            REG_POS_IGAIN:  rd_val = r_cfg.position_integral_step_gain;
            REG_YAW_IGAIN:  rd_val = r_cfg.yaw_integral_step_gain;
            REG_VEL_LIMIT:  rd_val = r_cfg.velocity_limit;
            REG_YAW_LIMIT:  rd_val = r_cfg.turn_rate_limit;
            REG_POS_WINDUP: rd_val = r_cfg.position_windup_value;
            REG_YAW_WINDUP: rd_val = r_cfg.yaw_windup_value;
            default:        rd_val = GAIN_ZERO;
        endcase
    end

    assign prdata = {{(DATA_W-GAIN_W){1'b0}}, rd_val};
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

`default_nettype wire

[rtl/core/pivca_gain_stage.sv]
// Input register, error forming and gain products for the PI velocity controller.
`timescale 1ns / 1ps
`default_nettype none

module pivca_gain_stage #(
    parameter int FRACTION_BITS = pivca_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  pivca_pkg::t_cfg        i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  pivca_pkg::t_sample     i_sample,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output pivca_pkg::t_terms      o_terms
);
    import pivca_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    t_sample r_in;
    logic    r_in_valid;
    t_terms  r_terms;
    logic    r_terms_valid;
    t_terms  n_terms;
    logic    terms_ready;

    logic signed [DATA_W-1:0] err_x;
    logic signed [DATA_W-1:0] err_y;
    logic signed [DATA_W-1:0] err_z;
    logic signed [DATA_W-1:0] err_yaw;

    function automatic logic signed [DATA_W-1:0] err_of(
        input logic signed [DATA_W-1:0] target,
        input logic signed [DATA_W-1:0] sensed
    );
        logic signed [DATA_W:0] d;
        d = {target[DATA_W-1], target} - {sensed[DATA_W-1], sensed};
        return sat_grow1(d);
    endfunction

    // Floor-shifted product, saturated to the data range.
    function automatic logic signed [DATA_W-1:0] mul_term(
        input logic signed [DATA_W-1:0] a,
        input logic        [GAIN_W-1:0] g
    );
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] q;
        logic signed [DATA_W-1:0] r;
        p = a * $signed({1'b0, g});
        q = p >>> FRACTION_BITS;
        if ((&q[PROD_W-1:DATA_W-1]) || !(|q[PROD_W-1:DATA_W-1])) begin
            r = q[DATA_W-1:0];
        end else begin
            r = q[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    assign terms_ready = !r_terms_valid || i_ready;
    assign o_ready     = !r_in_valid || terms_ready;

    always_comb begin
        err_x   = err_of(r_in.target_x,   r_in.sensed_x);
        err_y   = err_of(r_in.target_y,   r_in.sensed_y);
        err_z   = err_of(r_in.target_z,   r_in.sensed_z);
        err_yaw = err_of(r_in.target_yaw, r_in.sensed_yaw);

        n_terms.prop_x            = mul_term(err_x,   i_cfg.pos_kp);
        n_terms.prop_y            = mul_term(err_y,   i_cfg.pos_kp);
        n_terms.prop_z            = mul_term(err_z,   i_cfg.pos_kp);
        n_terms.prop_yaw          = mul_term(err_yaw, i_cfg.yaw_kp);
        n_terms.integ_x           = mul_term(err_x,   i_cfg.position_integral_step_gain);
        n_terms.integ_y           = mul_term(err_y,   i_cfg.position_integral_step_gain);
        n_terms.integ_yaw         = mul_term(err_yaw, i_cfg.yaw_integral_step_gain);
        n_terms.clear_integrators = r_in.clear_integrators;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_terms_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (terms_ready) begin
                r_terms_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_sample;
        end
        if (terms_ready && r_in_valid) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_terms_valid;
    assign o_terms = r_terms;

endmodule

`default_nettype wire

[rtl/core/pivca_integ_stage.sv]
// Integrators, back-calculation anti-windup, clamping and result register.
`timescale 1ns / 1ps
`default_nettype none

module pivca_integ_stage (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  pivca_pkg::t_cfg                          i_cfg,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  pivca_pkg::t_terms                        i_terms,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [pivca_pkg::DATA_W-1:0]      o_velocity_x,
    output logic signed [pivca_pkg::DATA_W-1:0]      o_velocity_y,
    output logic signed [pivca_pkg::DATA_W-1:0]      o_velocity_z,
    output logic signed [pivca_pkg::DATA_W-1:0]      o_turn_rate
);
    import pivca_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] cmd;
        logic signed [DATA_W-1:0] integ;
    } t_axis;

    logic signed [DATA_W-1:0] r_integ_x;
    logic signed [DATA_W-1:0] r_integ_y;
    logic signed [DATA_W-1:0] r_integ_yaw;
    logic signed [DATA_W-1:0] r_vel_x;
    logic signed [DATA_W-1:0] r_vel_y;
    logic signed [DATA_W-1:0] r_vel_z;
    logic signed [DATA_W-1:0] r_turn_rate;
    logic                     r_out_valid;

    logic signed [DATA_W-1:0] base_x;
    logic signed [DATA_W-1:0] base_y;
    logic signed [DATA_W-1:0] base_yaw;
    t_axis                    n_x;
    t_axis                    n_y;
    t_axis                    n_yaw;
    logic signed [DATA_W-1:0] n_vel_z;
    logic                     take;

    function automatic logic signed [DATA_W-1:0] clamp_lim(
        input logic signed [DATA_W:0] v,
        input logic        [GAIN_W-1:0] lim
    );
        logic signed [DATA_W:0]   lim_p;
        logic signed [DATA_W:0]   lim_n;
        logic signed [DATA_W-1:0] r;
        lim_p = {2'b00, lim};
        lim_n = -lim_p;
        if (v > lim_p) begin
            r = lim_p[DATA_W-1:0];
        end else if (v < lim_n) begin
            r = lim_n[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic t_axis back_calc(
        input logic signed [DATA_W-1:0] base,
        input logic signed [DATA_W-1:0] step,
        input logic signed [DATA_W-1:0] prop,
        input logic        [GAIN_W-1:0] lim,
        input logic        [GAIN_W-1:0] wind
    );
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W:0]   sum;
        logic signed [DATA_W:0]   lim_p;
        logic signed [DATA_W-1:0] wind_p;
        t_axis                    r;
        acc    = sat_grow1({base[DATA_W-1], base} + {step[DATA_W-1], step});
        sum    = {prop[DATA_W-1], prop} + {acc[DATA_W-1], acc};
        lim_p  = {2'b00, lim};
        wind_p = {1'b0, wind};
        r.cmd  = clamp_lim(sum, lim);
        if (sum > lim_p) begin
            r.integ = -wind_p;
        end else if (sum < -lim_p) begin
            r.integ = wind_p;
        end else begin
            r.integ = acc;
        end
        return r;
    endfunction

    assign o_ready = !r_out_valid || i_ready;
    assign take    = o_ready && i_valid;

    always_comb begin
        base_x   = i_terms.clear_integrators ? '0 : r_integ_x;
        base_y   = i_terms.clear_integrators ? '0 : r_integ_y;
        base_yaw = i_terms.clear_integrators ? '0 : r_integ_yaw;
        n_x      = back_calc(base_x, i_terms.integ_x, i_terms.prop_x,
                             i_cfg.velocity_limit, i_cfg.position_windup_value);
        n_y      = back_calc(base_y, i_terms.integ_y, i_terms.prop_y,
                             i_cfg.velocity_limit, i_cfg.position_windup_value);
        n_yaw    = back_calc(base_yaw, i_terms.integ_yaw, i_terms.prop_yaw,
                             i_cfg.turn_rate_limit, i_cfg.yaw_windup_value);
        n_vel_z  = clamp_lim({i_terms.prop_z[DATA_W-1], i_terms.prop_z},
                             i_cfg.velocity_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_integ_x   <= '0;
            r_integ_y   <= '0;
            r_integ_yaw <= '0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (take) begin
                r_integ_x   <= n_x.integ;
                r_integ_y   <= n_y.integ;
                r_integ_yaw <= n_yaw.integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_vel_x     <= n_x.cmd;
            r_vel_y     <= n_y.cmd;
            r_vel_z     <= n_vel_z;
            r_turn_rate <= n_yaw.cmd;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_velocity_x = r_vel_x;
    assign o_velocity_y = r_vel_y;
    assign o_velocity_z = r_vel_z;
    assign o_turn_rate  = r_turn_rate;

endmodule

`default_nettype wire

[rtl/core/pi_velocity_controller_antiwindup.sv]
// Top level of the PI position-to-velocity controller with back-calculation anti-windup.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_sensed_*, i_target_*, i_clear_integrators
//  output    out        o_out_valid / i_out_ready  o_velocity_x/y/z, o_turn_rate
//  config    in         psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// One beat per cycle unless the output stalls; o_out_valid is set by the result register.
// Stage one registers the input, stage two holds the seven gain products (one 32x32 multiplier
// each), stage three runs the integrator loop and registers the result.
// Synchronous active-low reset empties the pipeline, zeroes the integrators and loads the
// register defaults. An output stall backs up stage by stage; empty stages keep taking beats.
`timescale 1ns / 1ps
`default_nettype none

module pi_velocity_controller_antiwindup #(
    parameter int FRACTION_BITS = pivca_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pivca_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [pivca_pkg::DATA_W-1:0]        pwdata,
    output logic      [pivca_pkg::DATA_W-1:0]        prdata,
    output logic                                     pready,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [pivca_pkg::DATA_W-1:0] i_sensed_x,
    input  wire logic signed [pivca_pkg::DATA_W-1:0] i_sensed_y,
    input  wire logic signed [pivca_pkg::DATA_W-1:0] i_sensed_z,
    input  wire logic signed [pivca_pkg::DATA_W-1:0] i_sensed_yaw,
    input  wire logic signed [pivca_pkg::DATA_W-1:0] i_target_x,
    input  wire logic signed [pivca_pkg::DATA_W-1:0] i_target_y,
    input  wire logic signed [pivca_pkg::DATA_W-1:0] i_target_z,
    input  wire logic signed [pivca_pkg::DATA_W-1:0] i_target_yaw,
    input  wire logic                                i_clear_integrators,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [pivca_pkg::DATA_W-1:0]      o_velocity_x,
    output logic signed [pivca_pkg::DATA_W-1:0]      o_velocity_y,
    output logic signed [pivca_pkg::DATA_W-1:0]      o_velocity_z,
    output logic signed [pivca_pkg::DATA_W-1:0]      o_turn_rate
);
    import pivca_pkg::*;

    t_cfg    cfg;
    t_sample sample;
    t_terms  terms;
    logic    terms_valid;
    logic    terms_ready;

    assign sample.sensed_x          = i_sensed_x;
    assign sample.sensed_y          = i_sensed_y;
    assign sample.sensed_z          = i_sensed_z;
    assign sample.sensed_yaw        = i_sensed_yaw;
    assign sample.target_x          = i_target_x;
    assign sample.target_y          = i_target_y;
    assign sample.target_z          = i_target_z;
    assign sample.target_yaw        = i_target_yaw;
    assign sample.clear_integrators = i_clear_integrators;

    pivca_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pivca_gain_stage #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (sample),
        .o_valid  (terms_valid),
        .i_ready  (terms_ready),
        .o_terms  (terms)
    );

    pivca_integ_stage u_integ (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (terms_valid),
        .o_ready      (terms_ready),
        .i_terms      (terms),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_velocity_x (o_velocity_x),
        .o_velocity_y (o_velocity_y),
        .o_velocity_z (o_velocity_z),
        .o_turn_rate  (o_turn_rate)
    );

endmodule

`default_nettype wire

[rtl/core/pivca_checker.sv]
// Port-level checker for the PI velocity controller and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "pi_velocity_controller_antiwindup_assert.svh"

module pivca_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_in_ready,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire logic signed [pivca_pkg::DATA_W-1:0] o_velocity_x,
    input wire logic signed [pivca_pkg::DATA_W-1:0] o_velocity_y,
    input wire logic signed [pivca_pkg::DATA_W-1:0] o_velocity_z,
    input wire logic signed [pivca_pkg::DATA_W-1:0] o_turn_rate
);

    logic [4*pivca_pkg::DATA_W-1:0] out_word;

    assign out_word = {o_velocity_x, o_velocity_y, o_velocity_z, o_turn_rate};

    `PIVCA_ASSERT_ALWAYS(a_rst_empties, i_clk, !i_rst_n |=> !o_out_valid)
    `PIVCA_ASSERT_RST(a_empty_takes, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)
    `PIVCA_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `PIVCA_ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(out_word))

endmodule

bind pi_velocity_controller_antiwindup pivca_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_velocity_x (o_velocity_x),
    .o_velocity_y (o_velocity_y),
    .o_velocity_z (o_velocity_z),
    .o_turn_rate  (o_turn_rate)
);

`default_nettype wire
